// File: design/vrd_pkg.sv
package vrd_pkg;

  // Protocol constants
  localparam logic [7:0] CRC_POLY    = 8'hD5;
  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  // Register reset values
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [7:0]  SEED_RESET    = 8'h00;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 1'b1;

  // Queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input mode codes as seen on the port
  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // Classified operation carried through the queue
  typedef enum logic [1:0] {
    OP_START,
    OP_BYTE,
    OP_TICK,
    OP_NONE
  } op_e;

  // Reported status codes
  typedef enum logic [1:0] {
    ST_WAIT = 2'd0,
    ST_IDLE = 2'd1,
    ST_OK   = 2'd2,
    ST_ERR  = 2'd3
  } status_e;

  // Receive phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ERROR,
    PH_SEEK,
    PH_SYNC2,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_CHECK
  } phase_e;

  // One classified word in the queue
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       is_sync1;
    logic       is_sync2;
  } qword_t;

  // One CRC-8 byte update, MSB first
  function automatic logic [7:0] crc_next(logic [7:0] crc, logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// File: design/vrd_front.sv
module vrd_front
  import vrd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] rx_byte_i,
  output logic       q_valid_o,
  input  logic       q_pop_i,
  output qword_t     q_word_o
);

  qword_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  qword_t             word_in;
  logic               push, pop;

  // Classify the incoming word
  always_comb begin
    word_in.data     = rx_byte_i;
    word_in.is_sync1 = (rx_byte_i == SYNC_FIRST);
    word_in.is_sync2 = (rx_byte_i == SYNC_SECOND);
    unique case (mode_e'(mode_i))
      MODE_START: word_in.op = OP_START;
      MODE_BYTE:  word_in.op = OP_BYTE;
      MODE_TICK:  word_in.op = OP_TICK;
      default:    word_in.op = OP_NONE;
    endcase
  end

  // Queue handshakes
  assign in_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign q_valid_o  = (count_q != '0);
  assign q_word_o   = entry_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= word_in;
    end
  end

endmodule

// File: design/vrd_back.sv
module vrd_back
  import vrd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  qword_t               q_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic                 payload_valid_o,
  output logic [7:0]           payload_byte_o,
  output logic [7:0]           payload_index_o,
  output logic [7:0]           frame_cmd_o,
  output logic [7:0]           frame_length_o
);

  logic [15:0] timeout_q;
  logic [7:0]  seed_q;

  phase_e      phase_q, phase_d;
  logic [7:0]  position_q, position_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] silence_q, silence_d;

  logic        out_valid_q, out_valid_d;
  status_e     status_q, status_d;
  logic        pvalid_q, pvalid_d;
  logic [7:0]  pbyte_q, pbyte_d;
  logic [7:0]  pidx_q, pidx_d;

  logic        take;
  logic        active;
  logic [7:0]  crc_upd;
  logic [7:0]  pos_inc;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      seed_q    <= SEED_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TIMEOUT: timeout_q <= cfg_data_i;
        CFG_SEED:    seed_q    <= cfg_data_i[7:0];
        default:     ;
      endcase
    end
  end

  // Take a word when the output register is free or being emptied
  assign take    = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = take;
  assign active  = (phase_q != PH_IDLE) && (phase_q != PH_ERROR);
  assign crc_upd = crc_next(crc_q, q_word_i.data);
  assign pos_inc = position_q + 8'd1;

  // Frame sequencer: next state and result
  always_comb begin
    phase_d     = phase_q;
    position_d  = position_q;
    crc_d       = crc_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    silence_d   = silence_q;
    pvalid_d    = 1'b0;
    pbyte_d     = '0;
    pidx_d      = '0;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;

    unique case (phase_q)
      PH_IDLE:  status_d = ST_IDLE;
      PH_ERROR: status_d = ST_ERR;
      default:  status_d = ST_WAIT;
    endcase

    if (take) begin
      out_valid_d = 1'b1;
      unique case (q_word_i.op)
        OP_START: begin
          phase_d    = PH_SEEK;
          position_d = '0;
          crc_d      = seed_q;
          cmd_d      = '0;
          len_d      = '0;
          silence_d  = '0;
          status_d   = ST_WAIT;
        end
        OP_BYTE: begin
          if (active) begin
            silence_d = '0;
            status_d  = ST_WAIT;
            unique case (phase_q)
              PH_SEEK: begin
                if (q_word_i.is_sync1) begin
                  phase_d = PH_SYNC2;
                end
              end
              PH_SYNC2: begin
                if (q_word_i.is_sync2) begin
                  phase_d = PH_CMD;
                end else begin
                  phase_d  = PH_ERROR;
                  status_d = ST_ERR;
                end
              end
              PH_CMD: begin
                crc_d   = crc_upd;
                cmd_d   = q_word_i.data;
                phase_d = PH_LEN;
              end
              PH_LEN: begin
                crc_d      = crc_upd;
                len_d      = q_word_i.data;
                position_d = '0;
                phase_d    = (q_word_i.data == 8'd0) ? PH_CHECK : PH_DATA;
              end
              PH_DATA: begin
                crc_d      = crc_upd;
                pvalid_d   = 1'b1;
                pbyte_d    = q_word_i.data;
                pidx_d     = position_q;
                position_d = pos_inc;
                if (pos_inc == len_q) begin
                  phase_d = PH_CHECK;
                end
              end
              PH_CHECK: begin
                if (q_word_i.data == crc_q) begin
                  phase_d  = PH_IDLE;
                  status_d = ST_OK;
                end else begin
                  phase_d  = PH_ERROR;
                  status_d = ST_ERR;
                end
              end
              default: ;
            endcase
          end
        end
        OP_TICK: begin
          if (active) begin
            if (silence_q >= timeout_q) begin
              phase_d  = PH_ERROR;
              status_d = ST_ERR;
            end else begin
              silence_d = silence_q + 16'd1;
              status_d  = ST_WAIT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      position_q  <= '0;
      crc_q       <= '0;
      cmd_q       <= '0;
      len_q       <= '0;
      silence_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      position_q  <= position_d;
      crc_q       <= crc_d;
      cmd_q       <= cmd_d;
      len_q       <= len_d;
      silence_q   <= silence_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register, loaded with each word taken
  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= status_d;
      pvalid_q <= pvalid_d;
      pbyte_q  <= pbyte_d;
      pidx_q   <= pidx_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign payload_valid_o = pvalid_q;
  assign payload_byte_o  = pbyte_q;
  assign payload_index_o = pidx_q;
  assign frame_cmd_o     = cmd_q;
  assign frame_length_o  = len_q;

endmodule

// File: design/vtx_response_deframer_crc8.sv
// Channel | Handshake               | Payload
// in      | in_valid_i / in_ready_o | mode_i, rx_byte_i
// out     | out_valid_o/out_ready_i | status_o, payload_*_o, frame_cmd_o, frame_length_o
// cfg     | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
// One word per cycle sustained while out_ready_i is high; acceptance writes a
// word to the two-entry queue, then the sequencer takes it when the result
// register is free or being emptied and loads its result. The CRC-8 byte update
// is combinational. Reset clears the queue, frame state and result valid; registers
// return to timeout 500 and seed 0. The input stalls only when the queue is full.
module vtx_response_deframer_crc8
  import vrd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           mode_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic                 payload_valid_o,
  output logic [7:0]           payload_byte_o,
  output logic [7:0]           payload_index_o,
  output logic [7:0]           frame_cmd_o,
  output logic [7:0]           frame_length_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  logic   q_valid;
  logic   q_pop;
  qword_t q_word;

  // Accept and classify
  vrd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .rx_byte_i  (rx_byte_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_word_o   (q_word)
  );

  // Frame sequencer and result register
  vrd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .q_valid_i       (q_valid),
    .q_pop_o         (q_pop),
    .q_word_i        (q_word),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .payload_valid_o (payload_valid_o),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .frame_cmd_o     (frame_cmd_o),
    .frame_length_o  (frame_length_o)
  );

endmodule

// File: tb/deframer_checker.sv
package deframer_tb_pkg;

  // CRC-8 over one byte, polynomial 0xD5, MSB first
  function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    r = acc ^ data;
    repeat (8) begin
      r = r[7] ? ((r << 1) ^ vrd_pkg::CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

module deframer_checker
  import vrd_pkg::*;
  import deframer_tb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [1:0]           mode_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [1:0]           status_i,
  input  logic                 payload_valid_i,
  input  logic [7:0]           payload_byte_i,
  input  logic [7:0]           payload_index_i,
  input  logic [7:0]           frame_cmd_i,
  input  logic [7:0]           frame_length_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e    status;
    logic       pay_valid;
    logic [7:0] pay_byte;
    logic [7:0] pay_index;
    logic [7:0] cmd;
    logic [7:0] length;
  } word_result_t;

  // Predicted deframer state and its registers
  phase_e      rx_phase;
  logic [7:0]  pay_pos;
  logic [7:0]  crc_acc;
  logic [7:0]  cmd_seen;
  logic [7:0]  len_seen;
  logic [15:0] silence_ticks;
  logic [15:0] tick_limit;
  logic [7:0]  seed_val;

  word_result_t results_due[$];
  int unsigned  fails = 0;
  int unsigned  pending_count = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending_count;

  task automatic report_mismatch(input string what);
    if (fails < 200) begin
      $display("[%0t] deframer mismatch: %s", $time, what);
    end
    fails++;
  endtask

  // Advance the predicted deframer by one word and give its result
  task automatic parse_word(input logic [1:0] mode, input logic [7:0] b,
                            output word_result_t r);
    logic receiving;
    receiving = (rx_phase != PH_IDLE) && (rx_phase != PH_ERROR);
    r = '0;
    r.status = (rx_phase == PH_IDLE) ? ST_IDLE :
               (rx_phase == PH_ERROR) ? ST_ERR : ST_WAIT;
    case (mode)
      MODE_START: begin
        rx_phase      = PH_SEEK;
        pay_pos       = '0;
        crc_acc       = seed_val;
        cmd_seen      = '0;
        len_seen      = '0;
        silence_ticks = '0;
        r.status      = ST_WAIT;
      end
      MODE_BYTE: if (receiving) begin
        silence_ticks = '0;
        case (rx_phase)
          PH_SEEK: if (b == SYNC_FIRST) rx_phase = PH_SYNC2;
          PH_SYNC2: begin
            if (b == SYNC_SECOND) begin
              rx_phase = PH_CMD;
            end else begin
              rx_phase = PH_ERROR;
              r.status = ST_ERR;
            end
          end
          PH_CMD: begin
            crc_acc  = crc8_update(crc_acc, b);
            cmd_seen = b;
            rx_phase = PH_LEN;
          end
          PH_LEN: begin
            crc_acc  = crc8_update(crc_acc, b);
            len_seen = b;
            pay_pos  = '0;
            rx_phase = (b == 8'h00) ? PH_CHECK : PH_DATA;
          end
          PH_DATA: begin
            crc_acc     = crc8_update(crc_acc, b);
            r.pay_valid = 1'b1;
            r.pay_byte  = b;
            r.pay_index = pay_pos;
            pay_pos     = pay_pos + 8'd1;
            if (pay_pos == len_seen) rx_phase = PH_CHECK;
          end
          PH_CHECK: begin
            if (b == crc_acc) begin
              rx_phase = PH_IDLE;
              r.status = ST_OK;
            end else begin
              rx_phase = PH_ERROR;
              r.status = ST_ERR;
            end
          end
          default: ;
        endcase
      end
      MODE_TICK: if (receiving) begin
        // silence already at the limit fails the reception
        if (silence_ticks >= tick_limit) begin
          rx_phase = PH_ERROR;
          r.status = ST_ERR;
        end else begin
          silence_ticks = silence_ticks + 16'd1;
        end
      end
      default: ;
    endcase
    r.cmd    = cmd_seen;
    r.length = len_seen;
  endtask

  // Compare results, follow register writes, predict accepted words
  always @(posedge clk_i or negedge rst_ni) begin : watch
    word_result_t due;
    if (!rst_ni) begin
      rx_phase      = PH_IDLE;
      pay_pos       = '0;
      crc_acc       = '0;
      cmd_seen      = '0;
      len_seen      = '0;
      silence_ticks = '0;
      tick_limit    = TIMEOUT_RESET;
      seed_val      = SEED_RESET;
      results_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          report_mismatch("result word with nothing awaited");
        end else begin
          due = results_due.pop_front();
          if (status_i !== due.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_i, due.status));
          if (payload_valid_i !== due.pay_valid)
            report_mismatch($sformatf("payload_valid %0b, expected %0b",
                                      payload_valid_i, due.pay_valid));
          if (payload_byte_i !== due.pay_byte)
            report_mismatch($sformatf("payload_byte %0h, expected %0h",
                                      payload_byte_i, due.pay_byte));
          if (payload_index_i !== due.pay_index)
            report_mismatch($sformatf("payload_index %0d, expected %0d",
                                      payload_index_i, due.pay_index));
          if (frame_cmd_i !== due.cmd)
            report_mismatch($sformatf("frame_cmd %0h, expected %0h", frame_cmd_i, due.cmd));
          if (frame_length_i !== due.length)
            report_mismatch($sformatf("frame_length %0d, expected %0d",
                                      frame_length_i, due.length));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TIMEOUT: tick_limit = cfg_data_i;
          CFG_SEED:    seed_val   = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        parse_word(mode_i, rx_byte_i, due);
        results_due.push_back(due);
      end
    end
    pending_count = results_due.size();
  end

endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vrd_pkg::*;
  import deframer_tb_pkg::*;

  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned WORDS_PER_PHASE = 350;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           mode;
  logic [7:0]           rx_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           status;
  logic                 payload_valid;
  logic [7:0]           payload_byte;
  logic [7:0]           payload_index;
  logic [7:0]           frame_cmd;
  logic [7:0]           frame_length;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  int unsigned fails;
  int unsigned pending;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned n_words = 0;
  int unsigned quiet_cycles = 0;
  logic [15:0] cur_timeout;
  logic [7:0]  cur_seed;

  always #5ns clk = ~clk;

  vtx_response_deframer_crc8 u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .mode_i          (mode),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .payload_valid_o (payload_valid),
    .payload_byte_o  (payload_byte),
    .payload_index_o (payload_index),
    .frame_cmd_o     (frame_cmd),
    .frame_length_o  (frame_length),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  deframer_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .mode_i          (mode),
    .rx_byte_i       (rx_byte),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .status_i        (status),
    .payload_valid_i (payload_valid),
    .payload_byte_i  (payload_byte),
    .payload_index_i (payload_index),
    .frame_cmd_i     (frame_cmd),
    .frame_length_i  (frame_length),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fails),
    .pending_o       (pending)
  );

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: too long without any word moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one word, with random gaps first; returns on the falling edge after acceptance
  task automatic send_word(input logic [1:0] m, input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    n_words++;
  endtask

  // Lower valid and wait until every result has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CFG_TIMEOUT) begin
      cur_timeout = data;
    end else begin
      cur_seed = data[7:0];
    end
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == SYNC_FIRST) b = ~b;
    return b;
  endfunction

  // A single tick or unused-mode word now and then; never enough to time out
  task automatic maybe_interject();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick == 0) send_word(MODE_TICK, 8'($urandom));
    else if (pick == 1) send_word(MODE_NONE, 8'($urandom));
  endtask

  // Sync pair, command, length, payload and CRC byte
  task automatic send_frame(input logic [7:0] len, input bit good_crc);
    logic [7:0] crc;
    logic [7:0] cmd;
    logic [7:0] b;
    cmd = 8'($urandom);
    crc = crc8_update(crc8_update(cur_seed, cmd), len);
    send_word(MODE_BYTE, SYNC_FIRST);
    maybe_interject();
    send_word(MODE_BYTE, SYNC_SECOND);
    maybe_interject();
    send_word(MODE_BYTE, cmd);
    maybe_interject();
    send_word(MODE_BYTE, len);
    for (int i = 0; i < len; i++) begin
      maybe_interject();
      b = 8'($urandom);
      crc = crc8_update(crc, b);
      send_word(MODE_BYTE, b);
    end
    maybe_interject();
    if (!good_crc) crc = crc ^ 8'($urandom_range(1, 255));
    send_word(MODE_BYTE, crc);
  endtask

  // Mostly well-formed frames with random content, the rest broken or noise
  task automatic random_traffic(input int unsigned count);
    int unsigned goal;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  len;
    goal = n_words + count;
    while (n_words < goal) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_word(MODE_START, 8'($urandom));
        repeat ($urandom_range(0, 2)) send_word(MODE_BYTE, noise_byte());
        len = ($urandom_range(39) == 0) ? 8'($urandom_range(7, 40)) :
                                          8'($urandom_range(0, 6));
        send_frame(len, $urandom_range(99) < 85);
      end else if (pick < 66) begin
        // bad second sync byte, then words into the error state
        send_word(MODE_START, 8'($urandom));
        send_word(MODE_BYTE, SYNC_FIRST);
        send_word(MODE_BYTE, 8'($urandom));
        repeat ($urandom_range(0, 3)) send_word(2'($urandom_range(1, 3)), 8'($urandom));
      end else if (pick < 72) begin
        // frame cut short; the next start restarts it
        send_word(MODE_START, 8'($urandom));
        send_word(MODE_BYTE, SYNC_FIRST);
        send_word(MODE_BYTE, SYNC_SECOND);
        send_word(MODE_BYTE, 8'($urandom));
        send_word(MODE_BYTE, 8'($urandom_range(1, 8)));
        repeat ($urandom_range(0, 3)) send_word(MODE_BYTE, 8'($urandom));
      end else if (pick < 82) begin
        // silence until the timeout fires
        send_word(MODE_START, 8'($urandom));
        send_word(MODE_BYTE, SYNC_FIRST);
        send_word(MODE_BYTE, SYNC_SECOND);
        n = (cur_timeout <= 40) ? cur_timeout + 1 : $urandom_range(1, 5);
        repeat (n) send_word(MODE_TICK, 8'($urandom));
        send_word(MODE_BYTE, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) send_word(2'($urandom_range(0, 3)), 8'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] rnd;
    in_valid    = 1'b0;
    mode        = MODE_NONE;
    rx_byte     = 8'h00;
    cfg_we      = 1'b0;
    cfg_index   = CFG_TIMEOUT;
    cfg_data    = 16'h0000;
    cur_timeout = TIMEOUT_RESET;
    cur_seed    = SEED_RESET;
    rst_n       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: idle words, noise, zero length, bad sync, error state, restart
    send_word(MODE_BYTE, 8'h00);
    send_word(MODE_TICK, 8'hFF);
    send_word(MODE_NONE, 8'h5A);
    send_word(MODE_START, 8'h00);
    send_word(MODE_NONE, 8'hFF);
    send_word(MODE_BYTE, 8'hFF);
    send_word(MODE_BYTE, 8'h00);
    send_word(MODE_BYTE, SYNC_FIRST);
    send_word(MODE_BYTE, SYNC_SECOND);
    send_word(MODE_BYTE, 8'hFF);
    send_word(MODE_BYTE, 8'h00);
    send_word(MODE_BYTE, crc8_update(crc8_update(cur_seed, 8'hFF), 8'h00));
    send_word(MODE_START, 8'hFF);
    send_word(MODE_BYTE, SYNC_FIRST);
    send_word(MODE_BYTE, 8'h54);
    send_word(MODE_BYTE, SYNC_FIRST);
    send_word(MODE_TICK, 8'h00);
    send_word(MODE_NONE, 8'h00);
    send_word(MODE_START, 8'h00);
    send_word(MODE_BYTE, SYNC_FIRST);
    send_word(MODE_BYTE, SYNC_SECOND);
    send_word(MODE_BYTE, 8'h00);
    send_word(MODE_START, 8'h00);
    send_frame(8'd2, 1'b0);

    // Tightest timeout, all-ones seed; sender idles little, receiver much
    settle();
    rnd = 16'($urandom);
    write_reg(CFG_TIMEOUT, 16'd1);
    write_reg(CFG_SEED, {rnd[15:8], 8'hFF});
    send_gap_pct = 9;
    stall_pct    = 55;
    random_traffic(WORDS_PER_PHASE);

    settle();
    rnd = 16'($urandom);
    write_reg(CFG_TIMEOUT, 16'($urandom_range(2, 30)));
    write_reg(CFG_SEED, rnd);
    send_gap_pct = 55;
    stall_pct    = 9;
    random_traffic(WORDS_PER_PHASE);

    // No idling; includes a frame of the longest length
    settle();
    rnd = 16'($urandom);
    write_reg(CFG_TIMEOUT, 16'($urandom_range(2, 40)));
    write_reg(CFG_SEED, rnd);
    send_gap_pct = 0;
    stall_pct    = 0;
    send_word(MODE_START, 8'($urandom));
    send_frame(8'd255, 1'b1);
    random_traffic(WORDS_PER_PHASE);

    // Longest timeout: a long silence stays well below it
    settle();
    rnd = 16'($urandom);
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    write_reg(CFG_SEED, {rnd[15:8], 8'h00});
    send_word(MODE_START, 8'($urandom));
    send_word(MODE_BYTE, SYNC_FIRST);
    send_word(MODE_BYTE, SYNC_SECOND);
    repeat (40) send_word(MODE_TICK, 8'($urandom));
    send_word(MODE_BYTE, 8'($urandom));
    send_word(MODE_START, 8'($urandom));
    send_frame(8'd3, 1'b1);

    settle();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
